// File: hdl/llq_pkg.sv
// Shared types and constants for the linked-list queue manager.
// No dependencies; the queue manager and its testbench import this package.
package llq_pkg;

   localparam int ITEM_W        = 6;
   localparam int CMD_W         = 3;
   localparam int MAX_ITEMS_DEF = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT    = 3'd0,
      CMD_PUSH   = 3'd1,
      CMD_GET    = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT_LINK,
      ST_POP,
      ST_WALK,
      ST_FIX,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ITEM_W-1:0] item_id;
   } req_payload_type;

   typedef struct packed {
      logic [ITEM_W-1:0] got_item;
      logic              hit;
      logic              now_empty;
   } rsp_payload_type;

endpackage

// File: hdl/llq_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Payload type is a parameter; the queue manager uses llq_pkg structs.
interface llq_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/linked_list_queue_manager.sv
// Linked-list queue manager: queue of item numbers kept as a next-link table.
// Depends on llq_pkg and llq_stream_if.
//
// Usage:
//   req_chan carries one command word {cmd, item_id}: put at tail, push at
//   head, get head, remove a named item, query membership. rsp_chan returns
//   exactly one word {got_item, hit, now_empty} for every accepted command.
//   req_chan.ready is high while the sequencer is idle; a command is taken
//   when valid and ready are both high.
// Command paths, accept to response valid:
//   push, put onto an empty queue, unknown command, miss on empty or bad
//   item, query hit at the head: straight to ST_RESP; put onto a non-empty
//   queue, get of a queued item and remove of the head: through ST_PUT_LINK
//   or ST_POP first; remove and query walk the link table in ST_WALK, one
//   link read per cycle through the single read port. The next command is
//   taken in the cycle after the response is loaded.
// Reset (synchronous): the queue is empty and the sequencer idle. The link
//   table is not cleared; entries are written before they are followed.
// Stall: the response sits in an output register until rsp_chan.ready; the
//   block still accepts and works on the next command, and only waits if a
//   second response is ready before the first one is taken.
module linked_list_queue_manager
   import llq_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   llq_stream_if.sink          req_chan,
   llq_stream_if.source        rsp_chan
);

   localparam int LINK_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_ITEMS);
   localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(MAX_ITEMS - 1);

   // link table, one write and one registered read per cycle
   logic [LINK_W-1:0] link_mem [MAX_ITEMS];
   logic [LINK_W-1:0] rd_data_ff;
   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [LINK_W-1:0] wr_data;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LINK_W-1:0] item_ff, item_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  steps_ff, steps_in;
   logic [ITEM_W-1:0] got_ff, got_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              acc;
   cmd_type           in_cmd;
   logic [LINK_W-1:0] in_item;
   logic              in_ok;
   logic              head_nil;
   logic              walk_end;
   logic              rsp_free;

   assign acc      = req_chan.valid && (state_ff == ST_IDLE);
   assign in_cmd   = cmd_type'(req_chan.payload.cmd);
   assign in_item  = LINK_W'(req_chan.payload.item_id);
   assign in_ok    = 32'(req_chan.payload.item_id) < 32'(MAX_ITEMS);
   assign head_nil = (head_ff == NULL_LINK);
   assign walk_end = (steps_ff == LAST_STEP);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               case (in_cmd)
                  CMD_PUT:    state_in = (in_ok && !head_nil) ? ST_PUT_LINK : ST_RESP;
                  CMD_PUSH:   state_in = ST_RESP;
                  CMD_GET:    state_in = head_nil ? ST_RESP : ST_POP;
                  CMD_REMOVE: begin
                     if (!in_ok || head_nil)
                        state_in = ST_RESP;
                     else if (head_ff == in_item)
                        state_in = ST_POP;
                     else
                        state_in = ST_WALK;
                  end
                  CMD_QUERY: begin
                     if (!in_ok || head_nil || head_ff == in_item)
                        state_in = ST_RESP;
                     else
                        state_in = ST_WALK;
                  end
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_PUT_LINK: state_in = ST_RESP;
         ST_POP:      state_in = ST_RESP;
         ST_WALK: begin
            if (cmd_ff == CMD_REMOVE) begin
               if (rd_data_ff == NULL_LINK)
                  state_in = ST_RESP;
               else if (rd_data_ff == item_ff)
                  state_in = ST_FIX;
               else if (walk_end)
                  state_in = ST_RESP;
            end else begin
               if (walk_end || rd_data_ff == NULL_LINK || rd_data_ff == item_ff)
                  state_in = ST_RESP;
            end
         end
         ST_FIX:      state_in = ST_RESP;
         ST_RESP:     state_in = rsp_free ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and link table control
   always_comb begin
      cmd_in       = cmd_ff;
      item_in      = item_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      got_in       = got_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd_in   = in_cmd;
               item_in  = in_item;
               hit_in   = 1'b0;
               got_in   = (in_cmd == CMD_GET) ? ITEM_W'(head_ff) : '0;
               steps_in = '0;
               cur_in   = head_ff[IDX_W-1:0];
               // every command that follows the head needs its link
               rd_en    = !head_nil;
               rd_addr  = head_ff[IDX_W-1:0];
               case (in_cmd)
                  CMD_PUT: begin
                     if (in_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = in_item[IDX_W-1:0];
                        wr_data = NULL_LINK;
                        if (head_nil) begin
                           head_in = in_item;
                           tail_in = in_item[IDX_W-1:0];
                        end
                     end
                  end
                  CMD_PUSH: begin
                     if (in_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = in_item[IDX_W-1:0];
                        wr_data = head_ff;
                        head_in = in_item;
                        if (head_nil)
                           tail_in = in_item[IDX_W-1:0];
                     end
                  end
                  CMD_QUERY: hit_in = in_ok && !head_nil && (head_ff == in_item);
                  default: ;
               endcase
            end
         end
         ST_PUT_LINK: begin
            wr_en   = 1'b1;
            wr_addr = tail_ff;
            wr_data = item_ff;
            tail_in = item_ff[IDX_W-1:0];
         end
         ST_POP: begin
            head_in = rd_data_ff;
            hit_in  = 1'b1;
         end
         ST_WALK: begin
            if (cmd_ff == CMD_REMOVE) begin
               if (rd_data_ff != NULL_LINK && rd_data_ff == item_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = item_ff[IDX_W-1:0];
               end else if (rd_data_ff != NULL_LINK && !walk_end) begin
                  cur_in   = rd_data_ff[IDX_W-1:0];
                  steps_in = steps_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = rd_data_ff[IDX_W-1:0];
               end
            end else if (!walk_end && rd_data_ff != NULL_LINK) begin
               if (rd_data_ff == item_ff) begin
                  hit_in = 1'b1;
               end else begin
                  cur_in   = rd_data_ff[IDX_W-1:0];
                  steps_in = steps_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = rd_data_ff[IDX_W-1:0];
               end
            end
         end
         ST_FIX: begin
            // predecessor skips the removed item; tail moves back if needed
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = rd_data_ff;
            if (tail_ff == item_ff[IDX_W-1:0])
               tail_in = cur_ff;
            hit_in  = 1'b1;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.got_item  = got_ff;
               rsp_data_in.hit       = hit_ff;
               rsp_data_in.now_empty = head_nil;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         link_mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= NULL_LINK;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      item_ff     <= item_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      got_ff      <= got_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> head_ff == NULL_LINK && state_ff == ST_IDLE)
      else $error("queue not empty after reset");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && state_in == ST_IDLE |=> rsp_valid_ff)
      else $error("response lost when leaving response state");

   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> !wr_en)
      else $error("link table written during a walk");

   a_walk_cmd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> cmd_ff == CMD_REMOVE || cmd_ff == CMD_QUERY)
      else $error("walk started by a command that does not walk");

   a_fix_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX |-> $past(rd_data_ff) == item_ff)
      else $error("unlink without a matching predecessor");

endmodule

// File: sim/linked_list_queue_manager_tb.sv
`timescale 1ns / 1ps
// Testbench for linked_list_queue_manager: a directed table, then a random command mix.
// Response words are checked against an in-bench linked-list queue predictor, or a pinned row's word.
// Depends on llq_pkg, llq_stream_if and the queue manager RTL.
module linked_list_queue_manager_tb;
   import llq_pkg::*;

   localparam int               NUM_ITEMS      = MAX_ITEMS_DEF;
   localparam logic [6:0]       NIL_LINK       = 7'(NUM_ITEMS);
   localparam logic [CMD_W-1:0] CMD_UNUSED_5   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_6   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7   = 3'd7;
   localparam int               DIR_ROWS       = 25;
   localparam int               RAND_PER_PHASE = 500;
   localparam int               BURST_LEN      = 30;
   localparam int               LONG_HOLD      = 400;
   localparam int               DRAIN_CYCLES   = NUM_ITEMS + 16;
   localparam int               WATCHDOG_LIMIT = 4000;
   localparam int               MODE_GROW      = 0;
   localparam int               MODE_SHRINK    = 1;
   localparam int               MODE_MIXED     = 2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ITEM_W-1:0] item;
      logic              pinned;
      rsp_payload_type   want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   llq_stream_if #(.payload_type(req_payload_type)) cmd_bus ();
   llq_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   linked_list_queue_manager #(.MAX_ITEMS(NUM_ITEMS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (cmd_bus),
      .rsp_chan (rsp_bus)
   );

   always #2 clock = ~clock;

   // predicted queue state
   logic [6:0]        link_tab [NUM_ITEMS];
   logic [6:0]        head_ptr;
   logic [ITEM_W-1:0] tail_id;

   rsp_payload_type   pending_rsp_q [$];
   int                mismatches = 0;
   int                tx_idle_pct = 14;
   int                rx_idle_pct = 74;
   int                hold_reqs = 0;

   function automatic logic item_queued(input logic [ITEM_W-1:0] item);
      logic [6:0] cur;
      cur = head_ptr;
      for (int steps = 0; steps < NUM_ITEMS && cur != NIL_LINK; steps++) begin
         if (cur == {1'b0, item}) return 1'b1;
         cur = link_tab[cur[ITEM_W-1:0]];
      end
      return 1'b0;
   endfunction

   // bounded walk: a looped list reads as full length
   function automatic int queue_len();
      logic [6:0] cur;
      int         n;
      cur = head_ptr;
      n = 0;
      while (n < NUM_ITEMS && cur != NIL_LINK) begin
         n++;
         cur = link_tab[cur[ITEM_W-1:0]];
      end
      return n;
   endfunction

   function automatic logic [ITEM_W-1:0] nth_member(input int n);
      logic [6:0] cur;
      cur = head_ptr;
      for (int k = 0; k < n; k++) cur = link_tab[cur[ITEM_W-1:0]];
      return cur[ITEM_W-1:0];
   endfunction

   // applies one command to the predicted queue, returns the response word
   function automatic rsp_payload_type queue_op_result(input logic [CMD_W-1:0] cmd,
                                                       input logic [ITEM_W-1:0] item);
      rsp_payload_type r;
      logic [6:0]      cur;
      logic [6:0]      nx;
      logic [6:0]      item_link;
      r = '0;
      item_link = {1'b0, item};
      case (cmd)
         CMD_PUT: begin
            link_tab[item] = NIL_LINK;
            if (head_ptr == NIL_LINK) head_ptr = item_link;
            else link_tab[tail_id] = item_link;
            tail_id = item;
         end
         CMD_PUSH: begin
            link_tab[item] = head_ptr;
            head_ptr = item_link;
            if (link_tab[item] == NIL_LINK) tail_id = item;
         end
         CMD_GET: begin
            if (head_ptr != NIL_LINK) begin
               r.got_item = head_ptr[ITEM_W-1:0];
               r.hit = 1'b1;
               head_ptr = link_tab[head_ptr[ITEM_W-1:0]];
            end
         end
         CMD_REMOVE: begin
            if (head_ptr == item_link) begin
               head_ptr = link_tab[item];
               r.hit = 1'b1;
            end else if (head_ptr != NIL_LINK) begin
               // find the predecessor, unlink, pull the tail back if needed
               cur = head_ptr;
               for (int steps = 0; steps < NUM_ITEMS; steps++) begin
                  nx = link_tab[cur[ITEM_W-1:0]];
                  if (nx == NIL_LINK) break;
                  if (nx == item_link) begin
                     link_tab[cur[ITEM_W-1:0]] = link_tab[item];
                     if (tail_id == item) tail_id = cur[ITEM_W-1:0];
                     r.hit = 1'b1;
                     break;
                  end
                  cur = nx;
               end
            end
         end
         CMD_QUERY: r.hit = item_queued(item);
         default: ;
      endcase
      r.now_empty = (head_ptr == NIL_LINK);
      return r;
   endfunction

   task automatic pick_random_word(input int mode, output logic [CMD_W-1:0] cmd,
                                   output logic [ITEM_W-1:0] item);
      int                r;
      int                t_put;
      int                t_push;
      int                t_get;
      int                t_rem;
      int                t_qry;
      int                len;
      logic [ITEM_W-1:0] cand;
      case (mode)
         MODE_GROW: begin
            t_put = 45; t_push = 70; t_get = 80; t_rem = 88; t_qry = 96;
         end
         MODE_SHRINK: begin
            t_put = 10; t_push = 15; t_get = 50; t_rem = 80; t_qry = 96;
         end
         default: begin
            t_put = 25; t_push = 40; t_get = 60; t_rem = 80; t_qry = 96;
         end
      endcase
      r = $urandom_range(0, 99);
      item = ITEM_W'($urandom_range(0, NUM_ITEMS - 1));
      len = queue_len();
      if (r < t_push) begin
         cmd = (r < t_put) ? CMD_PUT : CMD_PUSH;
         // mostly fresh items; a rare duplicate insert is left through
         if ($urandom_range(0, 49) != 0 && item_queued(item)) begin
            cand = item;
            for (int k = 0; k < NUM_ITEMS && item_queued(cand); k++) cand = cand + 1'b1;
            if (item_queued(cand)) cmd = CMD_GET;
            else item = cand;
         end
      end else if (r < t_get) begin
         cmd = CMD_GET;
      end else if (r < t_qry) begin
         cmd = (r < t_rem) ? CMD_REMOVE : CMD_QUERY;
         if (len > 0 && $urandom_range(0, 99) < 65) item = nth_member($urandom_range(0, len - 1));
      end else begin
         case ($urandom_range(0, 2))
            0:       cmd = CMD_UNUSED_5;
            1:       cmd = CMD_UNUSED_6;
            default: cmd = CMD_UNUSED_7;
         endcase
      end
   endtask

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ITEM_W-1:0] item,
                            input logic pinned, input rsp_payload_type want);
      rsp_payload_type predicted;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         cmd_bus.valid = 1'b0;
         @(negedge clock);
      end
      cmd_bus.valid = 1'b1;
      cmd_bus.payload.cmd = cmd;
      cmd_bus.payload.item_id = item;
      do @(posedge clock); while (cmd_bus.ready !== 1'b1);
      predicted = queue_op_result(cmd, item);
      pending_rsp_q.push_back(pinned ? want : predicted);
      @(negedge clock);
   endtask

   initial begin : stimulus
      table_row_type     rows [DIR_ROWS];
      int                mode;
      logic [CMD_W-1:0]  cmd;
      logic [ITEM_W-1:0] item;
      rows = '{
         '{CMD_GET,      6'd0,  1'b1, '{6'd0, 1'b0, 1'b1}},  // get on empty queue
         '{CMD_REMOVE,   6'd63, 1'b1, '{6'd0, 1'b0, 1'b1}},  // remove on empty queue
         '{CMD_QUERY,    6'd0,  1'b1, '{6'd0, 1'b0, 1'b1}},
         '{CMD_UNUSED_5, 6'd63, 1'b1, '{6'd0, 1'b0, 1'b1}},  // unknown command
         '{CMD_PUT,      6'd0,  1'b1, '{6'd0, 1'b0, 1'b0}},
         '{CMD_PUT,      6'd63, 1'b0, '0},
         '{CMD_PUSH,     6'd1,  1'b0, '0},
         '{CMD_QUERY,    6'd63, 1'b0, '0},
         '{CMD_QUERY,    6'd2,  1'b0, '0},
         '{CMD_UNUSED_6, 6'd21, 1'b0, '0},
         '{CMD_REMOVE,   6'd63, 1'b0, '0},                   // tail moves back
         '{CMD_PUT,      6'd10, 1'b0, '0},
         '{CMD_REMOVE,   6'd1,  1'b0, '0},                   // remove the head
         '{CMD_REMOVE,   6'd7,  1'b0, '0},                   // not queued
         '{CMD_REMOVE,   6'd10, 1'b0, '0},
         '{CMD_GET,      6'd0,  1'b0, '0},
         '{CMD_GET,      6'd5,  1'b1, '{6'd0, 1'b0, 1'b1}},
         '{CMD_PUT,      6'd20, 1'b0, '0},
         '{CMD_PUT,      6'd20, 1'b0, '0},                   // duplicate: self loop
         '{CMD_QUERY,    6'd20, 1'b0, '0},
         '{CMD_GET,      6'd0,  1'b0, '0},
         '{CMD_PUT,      6'd21, 1'b0, '0},                   // breaks the loop again
         '{CMD_UNUSED_7, 6'd42, 1'b0, '0},
         '{CMD_GET,      6'd0,  1'b0, '0},
         '{CMD_GET,      6'd0,  1'b0, '0}
      };
      cmd_bus.valid = 1'b0;
      cmd_bus.payload = '0;
      for (int i = 0; i < NUM_ITEMS; i++) link_tab[i] = '0;
      head_ptr = NIL_LINK;
      tail_id = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_word(rows[i].cmd, rows[i].item, rows[i].pinned, rows[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 14; rx_idle_pct = 74;
            end
            1: begin
               tx_idle_pct = 74; rx_idle_pct = 14;
            end
            default: begin
               tx_idle_pct = 0; rx_idle_pct = 0;
            end
         endcase
         if (phase != 1) hold_reqs++;
         mode = MODE_MIXED;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (n % BURST_LEN == 0) mode = $urandom_range(MODE_GROW, MODE_MIXED);
            pick_random_word(mode, cmd, item);
            send_word(cmd, item, 1'b0, '0);
         end
      end
      cmd_bus.valid = 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // response side ready; a long hold lets the block back up into its input
   initial begin : rsp_ready_drive
      int hold_left;
      int served;
      hold_left = 0;
      served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (served != hold_reqs) begin
            served = hold_reqs;
            hold_left = LONG_HOLD - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response word with no command waiting: got_item %0d hit %0d now_empty %0d",
                   rsp_bus.payload.got_item, rsp_bus.payload.hit, rsp_bus.payload.now_empty);
            mismatches++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_bus.payload.got_item !== want.got_item) begin
               $error("got_item: expected %0d, actual %0d", want.got_item,
                      rsp_bus.payload.got_item);
               mismatches++;
            end
            if (rsp_bus.payload.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_bus.payload.hit);
               mismatches++;
            end
            if (rsp_bus.payload.now_empty !== want.now_empty) begin
               $error("now_empty: expected %0d, actual %0d", want.now_empty,
                      rsp_bus.payload.now_empty);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule
